[src/lte_pkg.sv]
// shared constants, widths and arithmetic helpers of the lorenz trajectory cost evaluator
`default_nettype none

package lte_pkg;

   // fixed-point format and run length
   localparam int FRAC_BITS = 20;
   localparam int MAX_STEPS = 500;

   // field layout of the point code
   localparam int CODE_W = 56;
   localparam int RAW_W  = 16;
   localparam int DUR_W  = 8;
   localparam int X_LSB  = 40;
   localparam int Y_LSB  = 24;
   localparam int Z_LSB  = 8;

   // datapath widths
   localparam int Q_W     = 32;
   localparam int SUM_W   = 36;
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int SQ_W    = 64;
   localparam int STEP_W  = $clog2(MAX_STEPS + 1);

   // division by 2^k - 1 for start scaling and step count, folded k bits at a time
   localparam int SPAN_W = 6;
   localparam int DIV_W  = RAW_W + SPAN_W + FRAC_BITS + 1;

   localparam longint RAW_MAX = 65535;
   localparam longint DUR_MAX = 255;
   localparam longint SPAN_X  = 40;
   localparam longint SPAN_Y  = 60;
   localparam longint SPAN_Z  = 50;

   // fixed-point constants
   localparam longint ONE_Q      = longint'(1) <<< FRAC_BITS;
   localparam longint HALF_Q     = ONE_Q >>> 1;
   localparam longint DT_Q       = (ONE_Q + 50) / 100;
   localparam longint DT_HALF_Q  = (ONE_Q + 100) / 200;
   localparam longint DT_SIXTH_Q = (ONE_Q + 300) / 600;
   localparam longint BETA_Q     = (8 * ONE_Q + 1) / 3;
   localparam longint OFFSET_X   = 20 * ONE_Q;
   localparam longint OFFSET_Y   = 30 * ONE_Q;
   localparam longint TARGET_X   = 18 * ONE_Q;
   localparam longint TARGET_Y   = 20 * ONE_Q;
   localparam longint TARGET_Z   = 45 * ONE_Q;

   // index of each division in the start-up sequence
   localparam logic [1:0] DIV_X     = 2'd0;
   localparam logic [1:0] DIV_Y     = 2'd1;
   localparam logic [1:0] DIV_Z     = 2'd2;
   localparam logic [1:0] DIV_STEPS = 2'd3;

   // clamp a wide signed value into the 32-bit coordinate range
   function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic all_same;
      all_same = (v[PROD_W-1:Q_W-1] == '0) || (v[PROD_W-1:Q_W-1] == '1);
      if (all_same) begin
         return v[Q_W-1:0];
      end
      return v[PROD_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
   endfunction

   // product back to Q format, nearest with ties upward, then clamp
   function automatic logic signed [Q_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + PROD_W'(HALF_Q);
      return sat32(t >>> FRAC_BITS);
   endfunction

   // magnitude limited to 32 bits
   function automatic logic [Q_W-1:0] mag32(input logic signed [PROD_W-1:0] d);
      logic [PROD_W-1:0] m;
      m = d[PROD_W-1] ? PROD_W'(-d) : PROD_W'(d);
      if (|m[PROD_W-1:Q_W]) begin
         return '1;
      end
      return m[Q_W-1:0];
   endfunction

   // sum of squares that sticks at all ones
   function automatic logic [SQ_W-1:0] sat_add64(input logic [SQ_W-1:0] a,
                                                 input logic [SQ_W-1:0] b);
      logic [SQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SQ_W] ? '1 : s[SQ_W-1:0];
   endfunction

   // dividend of each division
   function automatic logic [DIV_W-1:0] div_dividend(input logic [CODE_W-1:0] code,
                                                     input logic [1:0] idx);
      logic [DIV_W-1:0] raw;
      logic [DIV_W-1:0] span;
      logic [DIV_W-1:0] result;
      raw  = '0;
      span = '0;
      unique case (idx)
         DIV_X: begin
            raw  = DIV_W'(code[X_LSB +: RAW_W]);
            span = DIV_W'(SPAN_X);
         end
         DIV_Y: begin
            raw  = DIV_W'(code[Y_LSB +: RAW_W]);
            span = DIV_W'(SPAN_Y);
         end
         DIV_Z: begin
            raw  = DIV_W'(code[Z_LSB +: RAW_W]);
            span = DIV_W'(SPAN_Z);
         end
         DIV_STEPS: begin
            raw  = DIV_W'(code[DUR_W-1:0]);
            span = DIV_W'(MAX_STEPS);
         end
         default: begin
            raw  = '0;
            span = '0;
         end
      endcase
      if (idx == DIV_STEPS) begin
         result = raw * span + DIV_W'(DUR_MAX - 1);
      end else begin
         result = ((raw * span) << FRAC_BITS) + DIV_W'(RAW_MAX / 2);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[src/lorenz_trajectory_cost_evaluator_top.sv]
// Lorenz trajectory cost evaluator: sequencer around one shared multiplier
// Sequence: start-up division, then Euler or RK4 steps on the shared multiplier, then two
//   norms with their square roots, then hand-off of the result.
// Throughput: one item at a time; req_stall is low only while the sequencer is idle.
// Reset: synchronous, active high; clears the sequencer, method register and rsp_valid.
`default_nettype none

module lorenz_trajectory_cost_evaluator_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [lte_pkg::CODE_W-1:0]         req_point_code,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [lte_pkg::Q_W-1:0]          rsp_final_x,
   output logic signed [lte_pkg::Q_W-1:0]          rsp_final_y,
   output logic signed [lte_pkg::Q_W-1:0]          rsp_final_z,
   output logic [lte_pkg::Q_W-1:0]                 rsp_cost,
   input  wire logic                               csr_write_enable,
   input  wire logic [0:0]                         csr_write_data
);
   import lte_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_STEP = 6'b000100,
      ST_NORM = 6'b001000,
      ST_SQRT = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic method_ff, method_in;
   logic mode_ff, mode_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [CODE_W-1:0] code_ff, code_in;
   logic [1:0] div_idx_ff, div_idx_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] quot_ff, quot_in;

   logic signed [Q_W-1:0] stx_ff, stx_in, sty_ff, sty_in, stz_ff, stz_in;
   logic signed [Q_W-1:0] mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic signed [Q_W-1:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [Q_W-1:0] kx_ff, kx_in, ky_ff, ky_in, kz_ff, kz_in;
   logic signed [Q_W-1:0] t_ff, t_in;
   logic signed [SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [2:0] uop_ff, uop_in;
   logic [1:0] stage_ff, stage_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic pass_ff, pass_in;
   logic [SQ_W-1:0] acc_ff, acc_in;
   logic [SQ_W-1:0] v_ff, v_in;
   logic [SQ_W-1:0] res_ff, res_in;
   logic [4:0] sq_cnt_ff, sq_cnt_in;
   logic [Q_W-1:0] sqrt1_ff, sqrt1_in;
   logic signed [Q_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic [Q_W-1:0] out_cost_ff, out_cost_in;

   // shared multiplier operands
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;

   logic signed [Q_W-1:0] rnd;
   logic signed [MUL_B_W-1:0] h_sel;
   logic use_sum;
   logic write_m;
   logic signed [Q_W-1:0] kz_new;
   logic signed [PROD_W-1:0] dx_diff;
   logic signed [PROD_W-1:0] ky_sum;
   logic signed [Q_W-1:0] adv_val;
   logic [Q_W-1:0] mag0, mag1, mag2, mag_sel;
   logic [SQ_W-1:0] sq;
   logic [SQ_W-1:0] acc_sum;

   logic [DIV_W-1:0] div_hi;
   logic [DIV_W-1:0] div_lo;
   logic [DIV_W-1:0] div_mask;
   logic div_done;
   logic [DIV_W-1:0] div_q;
   logic signed [Q_W-1:0] start_val;

   logic [SQ_W-1:0] bitv;
   logic [SQ_W-1:0] trial;
   logic sq_ge;
   logic [SQ_W-1:0] res_next;
   logic [Q_W:0] cost_sum;
   logic load_out;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_final_x = out_x_ff;
   assign rsp_final_y = out_y_ff;
   assign rsp_final_z = out_z_ff;
   assign rsp_cost    = out_cost_ff;

   // rounded product of the previous cycle
   assign rnd = round_sat(prod_ff);

   // step size of the current rk4 stage, or the full step in euler mode
   always_comb begin
      unique case (stage_ff)
         2'd0, 2'd1: h_sel = MUL_B_W'(DT_HALF_Q);
         2'd2: h_sel = MUL_B_W'(DT_Q);
         2'd3: h_sel = MUL_B_W'(DT_SIXTH_Q);
         default: h_sel = MUL_B_W'(DT_Q);
      endcase
      if (!mode_ff) begin
         h_sel = MUL_B_W'(DT_Q);
      end
   end

   assign use_sum = mode_ff && (stage_ff == 2'd3);
   assign write_m = !mode_ff || (stage_ff == 2'd3);

   // lorenz derivative terms
   assign dx_diff = PROD_W'(ay_ff) - PROD_W'(ax_ff);
   assign ky_sum  = (PROD_W'(ax_ff) <<< 5) - (PROD_W'(ax_ff) <<< 2)
                    - PROD_W'(ay_ff) - PROD_W'(rnd);
   assign kz_new  = sat32(PROD_W'(t_ff) - PROD_W'(rnd));

   // advanced coordinate: m plus rounded product
   always_comb begin
      unique case (uop_ff)
         3'd5: adv_val = sat32(PROD_W'(mx_ff) + PROD_W'(rnd));
         3'd6: adv_val = sat32(PROD_W'(my_ff) + PROD_W'(rnd));
         default: adv_val = sat32(PROD_W'(mz_ff) + PROD_W'(rnd));
      endcase
   end

   // magnitudes for the two norms
   assign mag0 = pass_ff ? mag32(PROD_W'(mx_ff) - PROD_W'(TARGET_X)) : mag32(PROD_W'(stx_ff));
   assign mag1 = pass_ff ? mag32(PROD_W'(my_ff) - PROD_W'(TARGET_Y)) : mag32(PROD_W'(sty_ff));
   assign mag2 = pass_ff ? mag32(PROD_W'(mz_ff) - PROD_W'(TARGET_Z)) : mag32(PROD_W'(stz_ff));

   always_comb begin
      unique case (uop_ff)
         3'd0: mag_sel = mag0;
         3'd1: mag_sel = mag1;
         default: mag_sel = mag2;
      endcase
   end

   assign sq      = SQ_W'(prod_ff);
   assign acc_sum = sat_add64(acc_ff, sq);

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = MUL_A_W'(ax_ff);
      mul_b = MUL_B_W'(az_ff);
      if (state_ff == ST_NORM) begin
         mul_a = MUL_A_W'(mag_sel);
         mul_b = MUL_B_W'(mag_sel);
      end else begin
         unique case (uop_ff)
            3'd0: begin
               mul_a = MUL_A_W'(ax_ff);
               mul_b = MUL_B_W'(az_ff);
            end
            3'd1: begin
               mul_a = MUL_A_W'(ax_ff);
               mul_b = MUL_B_W'(ay_ff);
            end
            3'd2: begin
               mul_a = MUL_A_W'(BETA_Q);
               mul_b = MUL_B_W'(az_ff);
            end
            3'd4: begin
               mul_a = use_sum ? sx_ff : MUL_A_W'(kx_ff);
               mul_b = h_sel;
            end
            3'd5: begin
               mul_a = use_sum ? sy_ff : MUL_A_W'(ky_ff);
               mul_b = h_sel;
            end
            3'd6: begin
               mul_a = use_sum ? sz_ff : MUL_A_W'(kz_ff);
               mul_b = h_sel;
            end
            default: begin
               mul_a = MUL_A_W'(ax_ff);
               mul_b = MUL_B_W'(az_ff);
            end
         endcase
      end
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // one folding step of the division by 2^k - 1: n = hi*2^k + lo gives hi + (hi + lo)/m
   assign div_mask = (div_idx_ff == DIV_STEPS) ? DIV_W'(DUR_MAX) : DIV_W'(RAW_MAX);
   assign div_hi   = (div_idx_ff == DIV_STEPS) ? (dvd_ff >> DUR_W) : (dvd_ff >> RAW_W);
   assign div_lo   = dvd_ff & div_mask;
   assign div_done = (div_hi == '0);
   assign div_q    = quot_ff + DIV_W'(div_lo == div_mask);

   always_comb begin
      unique case (div_idx_ff)
         DIV_X: start_val = sat32($signed(PROD_W'(div_q)) - PROD_W'(OFFSET_X));
         DIV_Y: start_val = sat32($signed(PROD_W'(div_q)) - PROD_W'(OFFSET_Y));
         default: start_val = sat32($signed(PROD_W'(div_q)));
      endcase
   end

   // one step of the integer square root
   assign bitv     = {2'b01, {(SQ_W-2){1'b0}}} >> {sq_cnt_ff, 1'b0};
   assign trial    = res_ff + bitv;
   assign sq_ge    = (v_ff >= trial);
   assign res_next = sq_ge ? ((res_ff >> 1) + bitv) : (res_ff >> 1);
   assign cost_sum = {1'b0, sqrt1_ff} + (Q_W + 1)'(res_next);

   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer and datapath next state
   always_comb begin
      state_in    = state_ff;
      method_in   = method_ff;
      mode_in     = mode_ff;
      rsp_valid_in = rsp_valid_ff;
      code_in     = code_ff;
      div_idx_in  = div_idx_ff;
      dvd_in      = dvd_ff;
      quot_in     = quot_ff;
      stx_in      = stx_ff;
      sty_in      = sty_ff;
      stz_in      = stz_ff;
      mx_in       = mx_ff;
      my_in       = my_ff;
      mz_in       = mz_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      az_in       = az_ff;
      kx_in       = kx_ff;
      ky_in       = ky_ff;
      kz_in       = kz_ff;
      t_in        = t_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      sz_in       = sz_ff;
      uop_in      = uop_ff;
      stage_in    = stage_ff;
      steps_in    = steps_ff;
      pass_in     = pass_ff;
      acc_in      = acc_ff;
      v_in        = v_ff;
      res_in      = res_ff;
      sq_cnt_in   = sq_cnt_ff;
      sqrt1_in    = sqrt1_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_z_in    = out_z_ff;
      out_cost_in = out_cost_ff;

      // method register
      if (csr_write_enable) begin
         method_in = csr_write_data[0];
      end

      // result channel transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in    = req_point_code;
               mode_in    = method_ff;
               div_idx_in = DIV_X;
               dvd_in     = div_dividend(req_point_code, DIV_X);
               quot_in    = '0;
               state_in   = ST_DIV;
            end
         end

         ST_DIV: begin
            if (!div_done) begin
               dvd_in  = div_hi + div_lo;
               quot_in = quot_ff + div_hi;
            end else begin
               quot_in    = '0;
               div_idx_in = div_idx_ff + 1'b1;
               dvd_in     = div_dividend(code_ff, div_idx_ff + 1'b1);
               unique case (div_idx_ff)
                  DIV_X: stx_in = start_val;
                  DIV_Y: sty_in = start_val;
                  DIV_Z: stz_in = start_val;
                  DIV_STEPS: begin
                     steps_in = STEP_W'(div_q);
                     mx_in    = stx_ff;
                     my_in    = sty_ff;
                     mz_in    = stz_ff;
                     ax_in    = stx_ff;
                     ay_in    = sty_ff;
                     az_in    = stz_ff;
                     uop_in   = '0;
                     stage_in = '0;
                     pass_in  = 1'b0;
                     state_in = (div_q == '0) ? ST_NORM : ST_STEP;
                  end
                  default: begin
                     stx_in = stx_ff;
                  end
               endcase
            end
         end

         ST_STEP: begin
            uop_in = uop_ff + 1'b1;
            unique case (uop_ff)
               3'd1: begin
                  kx_in = sat32((dx_diff <<< 3) + (dx_diff <<< 1));
                  ky_in = sat32(ky_sum);
               end
               3'd2: begin
                  t_in = rnd;
               end
               3'd3: begin
                  kz_in = kz_new;
                  // weighted sum of the rk4 slopes
                  unique case (stage_ff)
                     2'd0: begin
                        sx_in = SUM_W'(kx_ff);
                        sy_in = SUM_W'(ky_ff);
                        sz_in = SUM_W'(kz_new);
                     end
                     2'd1, 2'd2: begin
                        sx_in = sx_ff + (SUM_W'(kx_ff) <<< 1);
                        sy_in = sy_ff + (SUM_W'(ky_ff) <<< 1);
                        sz_in = sz_ff + (SUM_W'(kz_new) <<< 1);
                     end
                     default: begin
                        sx_in = sx_ff + SUM_W'(kx_ff);
                        sy_in = sy_ff + SUM_W'(ky_ff);
                        sz_in = sz_ff + SUM_W'(kz_new);
                     end
                  endcase
               end
               3'd5: begin
                  ax_in = adv_val;
                  if (write_m) begin
                     mx_in = adv_val;
                  end
               end
               3'd6: begin
                  ay_in = adv_val;
                  if (write_m) begin
                     my_in = adv_val;
                  end
               end
               3'd7: begin
                  az_in = adv_val;
                  if (write_m) begin
                     mz_in    = adv_val;
                     stage_in = '0;
                     steps_in = steps_ff - 1'b1;
                     if (steps_ff == STEP_W'(1)) begin
                        pass_in  = 1'b0;
                        state_in = ST_NORM;
                     end
                  end else begin
                     stage_in = stage_ff + 1'b1;
                  end
               end
               default: begin
                  t_in = t_ff;
               end
            endcase
         end

         ST_NORM: begin
            uop_in = uop_ff + 1'b1;
            if (uop_ff == 3'd1) begin
               acc_in = sq;
            end else if (uop_ff == 3'd2) begin
               acc_in = acc_sum;
            end else if (uop_ff == 3'd3) begin
               v_in      = acc_sum;
               res_in    = '0;
               sq_cnt_in = '0;
               uop_in    = '0;
               state_in  = ST_SQRT;
            end
         end

         ST_SQRT: begin
            v_in      = sq_ge ? (v_ff - trial) : v_ff;
            res_in    = res_next;
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (sq_cnt_ff == '1) begin
               if (!pass_ff) begin
                  sqrt1_in = Q_W'(res_next);
                  pass_in  = 1'b1;
                  state_in = ST_NORM;
               end else begin
                  sqrt1_in = cost_sum[Q_W] ? '1 : cost_sum[Q_W-1:0];
                  state_in = ST_DONE;
               end
            end
         end

         // result registers change only once the previous result has gone
         ST_DONE: begin
            if (load_out) begin
               out_x_in     = mx_ff;
               out_y_in     = my_ff;
               out_z_in     = mz_ff;
               out_cost_in  = sqrt1_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         method_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_idx_ff   <= DIV_X;
         uop_ff       <= '0;
         stage_ff     <= '0;
         steps_ff     <= '0;
         pass_ff      <= 1'b0;
         sq_cnt_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         method_ff    <= method_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         div_idx_ff   <= div_idx_in;
         uop_ff       <= uop_in;
         stage_ff     <= stage_in;
         steps_ff     <= steps_in;
         pass_ff      <= pass_in;
         sq_cnt_ff    <= sq_cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      dvd_ff      <= dvd_in;
      quot_ff     <= quot_in;
      stx_ff      <= stx_in;
      sty_ff      <= sty_in;
      stz_ff      <= stz_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      mz_ff       <= mz_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      kx_ff       <= kx_in;
      ky_ff       <= ky_in;
      kz_ff       <= kz_in;
      t_ff        <= t_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      v_ff        <= v_in;
      res_ff      <= res_in;
      sqrt1_ff    <= sqrt1_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_cost_ff <= out_cost_in;
   end

   // sequencer checks
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_euler_single_stage: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) && !mode_ff |-> stage_ff == 2'd0)
      else $error("euler run left stage zero");

   a_steps_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> steps_ff != '0)
      else $error("integration running with no steps left");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not presented");

endmodule

`default_nettype wire
